/* hdl/bsl_pkg.sv */
// Package for the bytecode stack and local variable unit.
// Holds opcodes, status codes, constants, the shuffle tables and the command struct.
// No dependencies.
package bsl_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int LOCAL_COUNT_DEF = 256;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_UNDER   = 3'd2,
        ST_OVER    = 3'd3,
        ST_BADIDX  = 3'd4
    } t_status;

    localparam logic [7:0] OP_NOP         = 8'h00;
    localparam logic [7:0] OP_ACONST_NULL = 8'h01;
    localparam logic [7:0] OP_ICONST_5    = 8'h08;
    localparam logic [7:0] OP_LCONST_1    = 8'h0A;
    localparam logic [7:0] OP_FCONST_0    = 8'h0B;
    localparam logic [7:0] OP_FCONST_1    = 8'h0C;
    localparam logic [7:0] OP_FCONST_2    = 8'h0D;
    localparam logic [7:0] OP_DCONST_0    = 8'h0E;
    localparam logic [7:0] OP_DCONST_1    = 8'h0F;
    localparam logic [7:0] OP_BIPUSH      = 8'h10;
    localparam logic [7:0] OP_SIPUSH      = 8'h11;
    localparam logic [7:0] OP_ILOAD       = 8'h15;
    localparam logic [7:0] OP_ALOAD_3     = 8'h2D;
    localparam logic [7:0] OP_ISTORE      = 8'h36;
    localparam logic [7:0] OP_ASTORE_3    = 8'h4E;
    localparam logic [7:0] OP_POP         = 8'h57;
    localparam logic [7:0] OP_SWAP        = 8'h5F;

    localparam logic [31:0] F_ONE    = 32'h3F80_0000;
    localparam logic [31:0] F_TWO    = 32'h4000_0000;
    localparam logic [31:0] D_ONE_HI = 32'h3FF0_0000;

    // One command word from the controller to the datapath.
    typedef struct packed {
        logic        stk_rd;
        logic        stk_wr;
        logic        loc_rd;
        logic        loc_wr;
        logic        cap_stk;
        logic        cap_loc;
        logic        sp_upd;
        logic        emit;
        logic [2:0]  j;
        logic [2:0]  np;
        logic [2:0]  nq;
        logic [1:0]  vsel;
        logic        use_const;
        logic [31:0] cdata;
        logic [8:0]  lidx;
        t_status     status;
    } t_dp_cmd;

    function automatic logic [2:0] shuf_pops(input logic [3:0] k);
        logic [2:0] r;
        unique case (k)
            4'd0, 4'd2: r = 3'd1;
            4'd1, 4'd3, 4'd5, 4'd8: r = 3'd2;
            4'd4, 4'd6: r = 3'd3;
            4'd7: r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] shuf_npush(input logic [3:0] k);
        logic [2:0] r;
        unique case (k)
            4'd2, 4'd8: r = 3'd2;
            4'd3: r = 3'd3;
            4'd4, 4'd5: r = 3'd4;
            4'd6: r = 3'd5;
            4'd7: r = 3'd6;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Source of pushed slot j, as an index into the popped slots (0 is the old top).
    function automatic logic [1:0] shuf_src(input logic [3:0] k, input logic [2:0] j);
        logic [11:0] row;
        unique case (k)
            4'd3, 4'd8: row = 12'h004;
            4'd4: row = 12'h018;
            4'd5: row = 12'h011;
            4'd6: row = 12'h061;
            4'd7: row = 12'h1B1;
            default: row = 12'h000;
        endcase
        return row[2*j +: 2];
    endfunction

endpackage

/* hdl/bsl_ctrl.sv */
// Controller of the bytecode stack unit: decodes an opcode and sequences
// memory reads, writes and the result. Depends on bsl_pkg.
module bsl_ctrl #(
    parameter int STACK_DEPTH = 64,
    parameter int LOCAL_COUNT = 256,
    parameter int SPW         = 7
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_cmd,
    input  logic [15:0]     i_imm,
    input  logic [SPW-1:0]  i_sp,
    input  logic            i_out_free,
    output bsl_pkg::t_dp_cmd o_dp
);
    import bsl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_RD, S_RDC, S_WR, S_UPD, S_ORD, S_ORDC, S_EMIT
    } t_state;

    typedef enum logic [2:0] {K_NONE, K_CONST, K_LOAD, K_STORE, K_SHUF} t_kind;

    t_state      r_state;
    t_kind       r_kind;
    logic [7:0]  r_cmd;
    logic [15:0] r_imm;
    logic [2:0]  r_j, r_np, r_nq, r_nrd, r_nwr;
    logic [31:0] r_cv0, r_cv1;
    logic [8:0]  r_idx;
    logic [3:0]  r_k;
    t_status     r_status;

    t_kind       d_kind;
    logic [2:0]  d_np, d_nq, d_w, d_nrd, d_nwr;
    logic [31:0] d_cv0, d_cv1;
    logic [8:0]  d_idx;
    logic [3:0]  d_k;
    t_status     d_status;
    logic [7:0]  d_rel, d_rr;
    logic [2:0]  d_t;
    logic [SPW:0] d_after;

    always_comb begin
        d_kind = K_NONE;
        d_np = 3'd0;
        d_nq = 3'd0;
        d_w = 3'd1;
        d_cv0 = 32'd0;
        d_cv1 = 32'd0;
        d_idx = 9'd0;
        d_k = 4'd0;
        d_status = ST_OK;
        d_rel = 8'd0;
        d_rr = 8'd0;
        d_t = 3'd0;
        if (r_cmd == OP_NOP) begin
            d_kind = K_NONE;
        end else if (r_cmd <= OP_SIPUSH) begin
            d_kind = K_CONST;
            d_nq = 3'd1;
            if (r_cmd == OP_ACONST_NULL) begin
                d_cv0 = 32'd0;
            end else if (r_cmd <= OP_ICONST_5) begin
                d_cv0 = 32'(r_cmd) - 32'd3;
            end else if (r_cmd <= OP_LCONST_1) begin
                d_cv0 = 32'(r_cmd) - 32'd9;
                d_nq = 3'd2;
            end else if (r_cmd == OP_FCONST_0) begin
                d_cv0 = 32'd0;
            end else if (r_cmd == OP_FCONST_1) begin
                d_cv0 = F_ONE;
            end else if (r_cmd == OP_FCONST_2) begin
                d_cv0 = F_TWO;
            end else if (r_cmd == OP_DCONST_0) begin
                d_nq = 3'd2;
            end else if (r_cmd == OP_DCONST_1) begin
                d_cv1 = D_ONE_HI;
                d_nq = 3'd2;
            end else if (r_cmd == OP_BIPUSH) begin
                d_cv0 = {{24{r_imm[7]}}, r_imm[7:0]};
            end else begin
                d_cv0 = {{16{r_imm[15]}}, r_imm};
            end
        end else if ((r_cmd >= OP_ILOAD && r_cmd <= OP_ALOAD_3) ||
                     (r_cmd >= OP_ISTORE && r_cmd <= OP_ASTORE_3)) begin
            d_rel = (r_cmd >= OP_ISTORE) ? (r_cmd - OP_ISTORE) : (r_cmd - OP_ILOAD);
            if (d_rel < 8'd5) begin
                d_t = d_rel[2:0];
                d_idx = {1'b0, r_imm[7:0]};
            end else begin
                d_rr = d_rel - 8'd5;
                d_t = d_rr[4:2];
                d_idx = {7'd0, d_rr[1:0]};
            end
            d_w = (d_t == 3'd1 || d_t == 3'd3) ? 3'd2 : 3'd1;
            if (r_cmd >= OP_ISTORE) begin
                d_kind = K_STORE;
                d_np = d_w;
            end else begin
                d_kind = K_LOAD;
                d_nq = d_w;
            end
        end else if (r_cmd >= OP_POP && r_cmd <= OP_SWAP) begin
            d_kind = K_SHUF;
            d_k = 4'(r_cmd - OP_POP);
            d_np = shuf_pops(d_k);
            d_nq = shuf_npush(d_k);
        end else begin
            d_status = ST_UNKNOWN;
        end

        d_after = {1'b0, i_sp} - (SPW+1)'(d_np) + (SPW+1)'(d_nq);
        if (d_kind != K_NONE) begin
            if (i_sp < SPW'(d_np)) begin
                d_status = ST_UNDER;
            end else if (d_after > (SPW+1)'(STACK_DEPTH)) begin
                d_status = ST_OVER;
            end else if ((d_kind == K_LOAD || d_kind == K_STORE) &&
                         (10'(d_idx) + 10'(d_w) > 10'(LOCAL_COUNT))) begin
                d_status = ST_BADIDX;
            end
        end

        unique case (d_kind)
            K_LOAD:  d_nrd = d_nq;
            K_STORE: d_nrd = d_np;
            K_SHUF:  d_nrd = (d_nq == 3'd0) ? 3'd0 : d_np;
            default: d_nrd = 3'd0;
        endcase
        d_nwr = (d_kind == K_STORE) ? d_np : d_nq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_j <= 3'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_imm <= i_imm;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_kind <= d_kind;
                    r_np <= d_np;
                    r_nq <= d_nq;
                    r_nrd <= d_nrd;
                    r_nwr <= d_nwr;
                    r_cv0 <= d_cv0;
                    r_cv1 <= d_cv1;
                    r_idx <= d_idx;
                    r_k <= d_k;
                    r_status <= d_status;
                    r_j <= 3'd0;
                    if (d_status != ST_OK || d_kind == K_NONE) begin
                        r_state <= S_ORD;
                    end else if (d_nrd != 3'd0) begin
                        r_state <= S_RD;
                    end else if (d_nwr != 3'd0) begin
                        r_state <= S_WR;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_RD: r_state <= S_RDC;
                S_RDC: begin
                    if (r_j == r_nrd - 3'd1) begin
                        r_j <= 3'd0;
                        r_state <= (r_nwr != 3'd0) ? S_WR : S_UPD;
                    end else begin
                        r_j <= r_j + 3'd1;
                        r_state <= S_RD;
                    end
                end
                S_WR: begin
                    if (r_j == r_nwr - 3'd1) begin
                        r_j <= 3'd0;
                        r_state <= S_UPD;
                    end else begin
                        r_j <= r_j + 3'd1;
                    end
                end
                S_UPD: begin
                    r_j <= 3'd0;
                    r_state <= S_ORD;
                end
                S_ORD: r_state <= S_ORDC;
                S_ORDC: begin
                    if (r_j == 3'd1) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_j <= 3'd1;
                        r_state <= S_ORD;
                    end
                end
                S_EMIT: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_dp = '0;
        o_dp.j = r_j;
        o_dp.np = r_np;
        o_dp.nq = r_nq;
        o_dp.status = r_status;
        o_dp.lidx = r_idx + 9'(r_j);
        unique case (r_state)
            S_RD: begin
                if (r_kind == K_LOAD) o_dp.loc_rd = 1'b1;
                else o_dp.stk_rd = 1'b1;
            end
            S_RDC: begin
                if (r_kind == K_LOAD) o_dp.cap_loc = 1'b1;
                else o_dp.cap_stk = 1'b1;
            end
            S_WR: begin
                if (r_kind == K_STORE) begin
                    o_dp.loc_wr = 1'b1;
                    o_dp.vsel = 2'(r_np - 3'd1 - r_j);
                end else begin
                    o_dp.stk_wr = 1'b1;
                    if (r_kind == K_SHUF) begin
                        o_dp.vsel = shuf_src(r_k, r_j);
                    end else if (r_kind == K_LOAD) begin
                        o_dp.vsel = r_j[1:0];
                    end else begin
                        o_dp.use_const = 1'b1;
                        o_dp.cdata = (r_j == 3'd0) ? r_cv0 : r_cv1;
                    end
                end
            end
            S_UPD:  o_dp.sp_upd = 1'b1;
            S_ORD:  o_dp.stk_rd = 1'b1;
            S_ORDC: o_dp.cap_stk = 1'b1;
            S_EMIT: o_dp.emit = i_out_free;
            default: ;
        endcase
    end

endmodule

/* hdl/bsl_dpath.sv */
// Datapath of the bytecode stack unit: stack memory, local memory with valid
// bits, slot registers, stack pointer and the output register. Depends on bsl_pkg.
module bsl_dpath #(
    parameter int STACK_DEPTH = 64,
    parameter int LOCAL_COUNT = 256,
    parameter int SPW         = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bsl_pkg::t_dp_cmd i_dp,
    output logic [SPW-1:0]   o_sp,
    output logic             o_out_free,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [2:0]       o_status,
    output logic [SPW-1:0]   o_depth,
    output logic [31:0]      o_top_slot,
    output logic [31:0]      o_second_slot
);
    import bsl_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;

    logic [31:0]      r_stk [STACK_DEPTH];
    logic [31:0]      r_loc [LOCAL_COUNT];
    logic [LOCAL_COUNT-1:0] r_loc_vld;
    logic [31:0]      r_stk_rd, r_loc_rd;
    logic             r_loc_ok;
    logic [31:0]      r_v [4];
    logic [SPW-1:0]   r_sp;
    logic             r_o_vld;
    logic [2:0]       r_o_status;
    logic [SPW-1:0]   r_o_depth;
    logic [31:0]      r_o_top, r_o_sec;

    logic [SPW-1:0]   l_rd_full, l_wr_full;
    logic [AW-1:0]    l_stk_addr;
    logic [LW-1:0]    l_loc_addr;
    logic [31:0]      l_wdata;

    assign l_rd_full  = r_sp - SPW'(1) - SPW'(i_dp.j);
    assign l_wr_full  = r_sp - SPW'(i_dp.np) + SPW'(i_dp.j);
    assign l_stk_addr = i_dp.stk_wr ? l_wr_full[AW-1:0] : l_rd_full[AW-1:0];
    assign l_loc_addr = i_dp.lidx[LW-1:0];
    assign l_wdata    = i_dp.use_const ? i_dp.cdata : r_v[i_dp.vsel];

    // Single-port stack memory.
    always_ff @(posedge i_clk) begin
        if (i_dp.stk_wr) begin
            r_stk[l_stk_addr] <= l_wdata;
        end else if (i_dp.stk_rd) begin
            r_stk_rd <= r_stk[l_stk_addr];
        end
    end

    // Single-port local memory; entries never written read as zero.
    always_ff @(posedge i_clk) begin
        if (i_dp.loc_wr) begin
            r_loc[l_loc_addr] <= l_wdata;
        end else if (i_dp.loc_rd) begin
            r_loc_rd <= r_loc[l_loc_addr];
            r_loc_ok <= r_loc_vld[l_loc_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loc_vld <= '0;
        end else if (i_dp.loc_wr) begin
            r_loc_vld[l_loc_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp.cap_stk) begin
            r_v[i_dp.j[1:0]] <= r_stk_rd;
        end else if (i_dp.cap_loc) begin
            r_v[i_dp.j[1:0]] <= r_loc_ok ? r_loc_rd : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_dp.sp_upd) begin
            r_sp <= r_sp - SPW'(i_dp.np) + SPW'(i_dp.nq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_dp.emit) begin
            r_o_vld <= 1'b1;
        end else if (i_ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp.emit) begin
            r_o_status <= i_dp.status;
            r_o_depth <= r_sp;
            r_o_top <= (r_sp != '0) ? r_v[0] : 32'd0;
            r_o_sec <= (r_sp >= SPW'(2)) ? r_v[1] : 32'd0;
        end
    end

    assign o_sp          = r_sp;
    assign o_out_free    = !r_o_vld || i_ready;
    assign o_valid       = r_o_vld;
    assign o_status      = r_o_status;
    assign o_depth       = r_o_depth;
    assign o_top_slot    = r_o_top;
    assign o_second_slot = r_o_sec;

endmodule

/* hdl/bytecode_stack_local_unit_top.sv */
// Top level of the bytecode stack and local variable unit.
// Instantiates bsl_ctrl and bsl_dpath; depends on bsl_pkg.
//
// Input stream: one word per bytecode, tdata = {immediate[15:0], cmd[7:0]}.
// Output stream: one word per bytecode with the status, the stack depth after
// the step and the two top slots (zero where absent).
// An item is taken only while the unit is idle. It then passes through a decode
// step, a read and a capture for every slot read (stack or local), a write for
// every slot written, a stack pointer update, a read and a capture for each of
// the two top slots and the load of the output register. A failed step or a nop
// skips the slot reads, the writes and the stack pointer update. All stack reads
// and writes go through the single port of the stack memory in turn.
// The result sits in an output register; the next item is taken while it waits.
// If the receiver stalls, the unit finishes the next item and holds in its last
// state until the register frees.
// Reset clears the stack pointer, the valid bits of the locals (so every local
// reads as zero), the output valid flag and the control state.
module bytecode_stack_local_unit_top
    import bsl_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int LOCAL_COUNT = LOCAL_COUNT_DEF,
    parameter int DW = $clog2(STACK_DEPTH + 1),
    parameter int OW = ((3 + DW + 64 + 7) / 8) * 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [23:0]   s_axis_tdata,   // cmd[7:0], immediate[23:8]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [OW-1:0] m_axis_tdata    // status, depth, top_slot, second_slot, zero pad
);

    t_dp_cmd        w_dp;
    logic [DW-1:0]  w_sp;
    logic           w_out_free;
    logic [2:0]     w_status;
    logic [DW-1:0]  w_depth;
    logic [31:0]    w_top, w_sec;

    bsl_ctrl #(
        .STACK_DEPTH(STACK_DEPTH),
        .LOCAL_COUNT(LOCAL_COUNT),
        .SPW(DW)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_cmd(s_axis_tdata[7:0]),
        .i_imm(s_axis_tdata[23:8]),
        .i_sp(w_sp),
        .i_out_free(w_out_free),
        .o_dp(w_dp)
    );

    bsl_dpath #(
        .STACK_DEPTH(STACK_DEPTH),
        .LOCAL_COUNT(LOCAL_COUNT),
        .SPW(DW)
    ) u_dpath (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_dp(w_dp),
        .o_sp(w_sp),
        .o_out_free(w_out_free),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_status(w_status),
        .o_depth(w_depth),
        .o_top_slot(w_top),
        .o_second_slot(w_sec)
    );

    assign m_axis_tdata = OW'({w_sec, w_top, w_depth, w_status});

endmodule

/* hdl/bsl_chk.sv */
// Port checker for the bytecode stack unit, bound to the top level.
// Depends on bytecode_stack_local_unit_top.
module bsl_chk #(
    parameter int STACK_DEPTH = 64,
    parameter int DW = 7,
    parameter int OW = 80
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [OW-1:0] m_axis_tdata
);

    logic [2:0]    c_status;
    logic [DW-1:0] c_depth;
    logic [31:0]   c_top, c_sec;

    assign c_status = m_axis_tdata[2:0];
    assign c_depth  = m_axis_tdata[DW+2:3];
    assign c_top    = m_axis_tdata[DW+34:DW+3];
    assign c_sec    = m_axis_tdata[DW+66:DW+35];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while one is in progress");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> c_depth <= DW'(STACK_DEPTH) && c_status <= 3'd4)
        else $error("depth or status out of range");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && c_depth == '0 |-> c_top == 32'd0 && c_sec == 32'd0)
        else $error("slots shown on an empty stack");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && c_depth == DW'(1) |-> c_sec == 32'd0)
        else $error("second slot shown with one slot on the stack");

endmodule

bind bytecode_stack_local_unit_top bsl_chk #(
    .STACK_DEPTH(STACK_DEPTH),
    .DW(DW),
    .OW(OW)
) u_bsl_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

/* test/bytecode_stack_local_unit_top_test.sv */
// Self-checking testbench for the bytecode stack and local variable unit.
// Directed rows, overflow and stall tests, then random programs, checked by a predictor.
// Depends on bsl_pkg and bytecode_stack_local_unit_top.
module bytecode_stack_local_unit_top_test;
    import bsl_pkg::*;

    localparam int SDEPTH = STACK_DEPTH_DEF;
    localparam int LCOUNT = LOCAL_COUNT_DEF;
    localparam int DW = $clog2(SDEPTH + 1);
    localparam int OW = ((3 + DW + 64 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;

    // Packed from the highest bit down, so status lands in the lowest bits.
    typedef struct packed {
        logic [31:0]   second_slot;
        logic [31:0]   top_slot;
        logic [DW-1:0] depth;
        t_status       status;
    } t_outcome;

    typedef struct {
        logic [7:0]  cmd;
        logic [15:0] imm;
        logic        fixed;
        t_status     status;
        int          depth;
        logic [31:0] top_slot;
    } t_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [23:0]   s_axis_tdata;   // cmd[7:0], immediate[23:8]
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [OW-1:0] m_axis_tdata;   // status, depth, top_slot, second_slot, zero pad

    logic [31:0] model_stack [SDEPTH];
    logic [31:0] model_locals [LCOUNT];
    int          model_sp;
    t_outcome    pending_outcomes [$];
    int          mismatch_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;

    bytecode_stack_local_unit_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_outcome execute_bytecode(input logic [7:0] c, input logic [15:0] imm);
        t_outcome    r;
        t_status     st;
        logic [31:0] cv [2];
        logic [31:0] v [4];
        int          ncv;
        int          sp;
        int          rel;
        int          ty;
        int          idx;
        int          w;
        int          k;
        int          np;
        int          nq;
        logic        is_store;
        st = ST_OK;
        sp = model_sp;
        cv[0] = '0;
        cv[1] = '0;
        ncv = 0;
        if (c == OP_NOP) begin
        end else if (c <= OP_SIPUSH) begin
            if (c == OP_ACONST_NULL) ncv = 1;
            else if (c <= OP_ICONST_5) begin
                cv[0] = 32'(int'(c) - 3);
                ncv = 1;
            end else if (c <= OP_LCONST_1) begin
                cv[0] = 32'(c - 8'h09);
                ncv = 2;
            end else if (c == OP_FCONST_0) ncv = 1;
            else if (c == OP_FCONST_1) begin
                cv[0] = F_ONE;
                ncv = 1;
            end else if (c == OP_FCONST_2) begin
                cv[0] = F_TWO;
                ncv = 1;
            end else if (c == OP_DCONST_0) ncv = 2;
            else if (c == OP_DCONST_1) begin
                cv[1] = D_ONE_HI;
                ncv = 2;
            end else if (c == OP_BIPUSH) begin
                cv[0] = {{24{imm[7]}}, imm[7:0]};
                ncv = 1;
            end else begin
                cv[0] = {{16{imm[15]}}, imm};
                ncv = 1;
            end
            if (sp + ncv > SDEPTH) st = ST_OVER;
            else begin
                for (int i = 0; i < ncv; i++) model_stack[sp + i] = cv[i];
                sp += ncv;
            end
        end else if ((c >= OP_ILOAD && c <= OP_ALOAD_3) || (c >= OP_ISTORE && c <= OP_ASTORE_3)) begin
            is_store = c >= OP_ISTORE;
            rel = is_store ? int'(c - OP_ISTORE) : int'(c - OP_ILOAD);
            if (rel < 5) begin
                ty = rel;
                idx = imm[7:0];
            end else begin
                ty = (rel - 5) >> 2;
                idx = (rel - 5) & 3;
            end
            w = (ty == 1 || ty == 3) ? 2 : 1;
            if (is_store && sp < w) st = ST_UNDER;
            else if (!is_store && sp + w > SDEPTH) st = ST_OVER;
            else if (idx + w > LCOUNT) st = ST_BADIDX;
            else if (is_store) begin
                for (int i = 0; i < w; i++) model_locals[idx + i] = model_stack[sp - w + i];
                sp -= w;
            end else begin
                for (int i = 0; i < w; i++) model_stack[sp + i] = model_locals[idx + i];
                sp += w;
            end
        end else if (c >= OP_POP && c <= OP_SWAP) begin
            // Shuffle pop and push counts and the push order are written out per opcode.
            k = c - OP_POP;
            np = (k == 0 || k == 2) ? 1 : (k == 4 || k == 6) ? 3 : (k == 7) ? 4 : 2;
            nq = (k <= 1) ? 0 : (k == 3) ? 3 : (k == 4 || k == 5) ? 4 : (k == 6) ? 5 :
                 (k == 7) ? 6 : 2;
            if (sp < np) st = ST_UNDER;
            else if (sp - np + nq > SDEPTH) st = ST_OVER;
            else begin
                for (int i = 0; i < np; i++) v[i] = model_stack[sp - 1 - i];
                sp -= np;
                case (k)
                    2: begin model_stack[sp] = v[0]; model_stack[sp+1] = v[0]; end
                    3: begin model_stack[sp] = v[0]; model_stack[sp+1] = v[1];
                             model_stack[sp+2] = v[0]; end
                    4: begin model_stack[sp] = v[0]; model_stack[sp+1] = v[2];
                             model_stack[sp+2] = v[1]; model_stack[sp+3] = v[0]; end
                    5: begin model_stack[sp] = v[1]; model_stack[sp+1] = v[0];
                             model_stack[sp+2] = v[1]; model_stack[sp+3] = v[0]; end
                    6: begin model_stack[sp] = v[1]; model_stack[sp+1] = v[0];
                             model_stack[sp+2] = v[2]; model_stack[sp+3] = v[1];
                             model_stack[sp+4] = v[0]; end
                    7: begin model_stack[sp] = v[1]; model_stack[sp+1] = v[0];
                             model_stack[sp+2] = v[3]; model_stack[sp+3] = v[2];
                             model_stack[sp+4] = v[1]; model_stack[sp+5] = v[0]; end
                    8: begin model_stack[sp] = v[0]; model_stack[sp+1] = v[1]; end
                    default: ;
                endcase
                sp += nq;
            end
        end else st = ST_UNKNOWN;
        model_sp = sp;
        r.status = st;
        r.depth = DW'(sp);
        r.top_slot = sp >= 1 ? model_stack[sp - 1] : 32'd0;
        r.second_slot = sp >= 2 ? model_stack[sp - 2] : 32'd0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s at cycle %0d: got %h, expected %h", what, cycle_count, got, want);
        mismatch_count++;
    endtask

    // Sends one bytecode word and queues its predicted outcome. The word stays
    // offered after it is taken until the next send or a drain wait replaces it.
    task automatic send_bytecode(input logic [7:0] c, input logic [15:0] imm);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {imm, c};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_outcomes.push_back(execute_bytecode(c, imm));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    // Random opcode, weighted toward valid ones so the stack gets deep.
    function automatic logic [7:0] pick_opcode();
        int sel;
        sel = $urandom_range(99);
        if (sel < 30) return 8'($urandom_range(OP_SIPUSH));
        if (sel < 50) return 8'($urandom_range(OP_ALOAD_3, OP_ILOAD));
        if (sel < 65) return 8'($urandom_range(OP_ASTORE_3, OP_ISTORE));
        if (sel < 92) return 8'($urandom_range(OP_SWAP, OP_POP));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [15:0] pick_immediate();
        case ($urandom_range(3))
            0: return 16'($urandom_range(3));
            1: return 16'($urandom_range(255));
            2: return 16'($urandom_range(LCOUNT - 1, LCOUNT - 2));
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: random stalls plus the long hold-off on request.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[3 + DW + 63:0];
            if (pending_outcomes.size() == 0) begin
                report_mismatch("unexpected word", got.top_slot, 32'd0);
            end else begin
                want = pending_outcomes.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.depth != want.depth)
                    report_mismatch("depth", 32'(got.depth), 32'(want.depth));
                if (got.top_slot != want.top_slot)
                    report_mismatch("top_slot", got.top_slot, want.top_slot);
                if (got.second_slot != want.second_slot)
                    report_mismatch("second_slot", got.second_slot, want.second_slot);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    t_row directed [] = '{
        '{OP_NOP,          16'h0000, 1, ST_OK,      0, 32'd0},
        '{OP_POP,          16'h0000, 1, ST_UNDER,   0, 32'd0},
        '{OP_ISTORE,       16'h0000, 1, ST_UNDER,   0, 32'd0},
        '{8'hFF,           16'h0000, 1, ST_UNKNOWN, 0, 32'd0},
        '{8'h60,           16'h0000, 1, ST_UNKNOWN, 0, 32'd0},
        '{OP_ILOAD,        16'h00FF, 1, ST_OK,      1, 32'd0},
        '{OP_ILOAD + 8'd1, 16'h00FF, 1, ST_BADIDX,  1, 32'd0},
        '{8'h02,           16'h0000, 1, ST_OK,      2, 32'hFFFF_FFFF},
        '{OP_ICONST_5,     16'h0000, 1, ST_OK,      3, 32'd5},
        '{OP_BIPUSH,       16'hFF80, 1, ST_OK,      4, 32'hFFFF_FF80},
        '{OP_BIPUSH,       16'h7F7F, 1, ST_OK,      5, 32'h0000_007F},
        '{OP_SIPUSH,       16'h8000, 1, ST_OK,      6, 32'hFFFF_8000},
        '{OP_SIPUSH,       16'h7FFF, 1, ST_OK,      7, 32'h0000_7FFF},
        '{OP_FCONST_1,     16'h0000, 1, ST_OK,      8, F_ONE},
        '{OP_FCONST_2,     16'h0000, 1, ST_OK,      9, F_TWO},
        '{OP_DCONST_1,     16'h0000, 1, ST_OK,     11, D_ONE_HI},
        '{OP_LCONST_1,     16'h0000, 0, ST_OK,      0, 32'd0},
        '{OP_ISTORE + 8'd1, 16'hFF00, 0, ST_OK,     0, 32'd0},
        '{OP_ISTORE + 8'd3, 16'h00FE, 0, ST_OK,     0, 32'd0},
        '{OP_ILOAD + 8'd3, 16'h01FE, 0, ST_OK,      0, 32'd0},
        '{8'h5D,           16'h0000, 0, ST_OK,      0, 32'd0},
        '{8'h5E,           16'h0000, 0, ST_OK,      0, 32'd0},
        '{8'h5A,           16'h0000, 0, ST_OK,      0, 32'd0},
        '{OP_SWAP,         16'h0000, 0, ST_OK,      0, 32'd0},
        '{OP_ASTORE_3,     16'h0000, 0, ST_OK,      0, 32'd0}
    };

    initial begin
        int phase;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        model_sp = 0;
        for (int i = 0; i < SDEPTH; i++) model_stack[i] = '0;
        for (int i = 0; i < LCOUNT; i++) model_locals[i] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n]) begin
            t_outcome want;
            send_bytecode(directed[n].cmd, directed[n].imm);
            want = pending_outcomes[$];
            if (directed[n].fixed && (want.status != directed[n].status ||
                    int'(want.depth) != directed[n].depth ||
                    want.top_slot != directed[n].top_slot))
                report_mismatch("directed row table", want.top_slot, directed[n].top_slot);
        end
        // Fill to the limit, then overflow the push and shuffle paths.
        while (model_sp < SDEPTH) send_bytecode(OP_ICONST_5, 16'h0000);
        send_bytecode(OP_ACONST_NULL, 16'h0000);
        send_bytecode(8'h5C, 16'h0000);
        send_bytecode(OP_ILOAD, 16'h0000);

        // Long receiver hold-off while the sender keeps offering words.
        hold_off_cycles = 400;
        for (int i = 0; i < 10; i++) send_bytecode(OP_POP, 16'h0000);
        wait_drained();

        for (int n = 0; n < 800; n++) begin
            phase = (n / 50) % 4;
            send_idle_pct = (phase == 1 || phase == 3) ? 86 : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? 86 : 0;
            if (phase == 3) begin
                send_idle_pct = 8;
                recv_stall_pct = 8;
            end
            if (n % 100 == 99) wait_drained();
            // Drain the stack now and then so that the pop paths see use.
            if (model_sp > 56 && $urandom_range(1)) send_bytecode(8'h58, 16'($urandom));
            else send_bytecode(pick_opcode(), pick_immediate());
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/bsl_pkg.sv
hdl/bsl_ctrl.sv
hdl/bsl_dpath.sv
hdl/bytecode_stack_local_unit_top.sv
hdl/bsl_chk.sv
test/bytecode_stack_local_unit_top_test.sv
